// ----- sv/ldc_pkg.sv -----
// ldc_pkg: shared types for the longest dominance chain block
// no dependencies; used by the sort cells and the top level
`default_nettype none

package ldc_pkg;

  // control handed to every cell of the sorting row
  typedef struct packed {
    logic ins_en;    // insert the incoming key this cycle
    logic drain_en;  // shift the row one place toward cell 0
  } row_ctrl_t;

  // result field width and saturation value
  localparam int unsigned LenW   = 7;
  localparam int unsigned LenSat = 127;

  // sequencer states
  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

endpackage

`default_nettype wire

// ----- sv/longest_dominance_chain.sv -----
// longest_dominance_chain: top level, sequencer and the two cell rows
// depends on ldc_pkg, ldc_sort_cell and ldc_tail_cell
//
// Points load one item per cycle. Each point is turned into an order-keeping
// key (x and y with inverted sign bits, packed x:y) and dropped straight into
// its sorted place in a row of MAX_POINTS sort cells, so the set is already in
// ascending x, then y order when the last item arrives. A point that arrives
// while the row is full is dropped and sets the overflow flag. After the item
// with is_last, input stalls through the run, and longer while an earlier
// result still sits unaccepted in the output register: the sort row drains
// one point per cycle from its head into a row of MAX_POINTS tail cells,
// where each cell keeps the smallest y that ends a non-decreasing chain of its
// length; an item moves one cell per cycle until it lands on the first tail
// above it. Every landing on an empty cell lengthens the longest chain by one,
// which a counter tracks. The length (saturated at 127) and the overflow flag
// then go to an output register, and loading of the next set starts at once,
// while that result waits.
`default_nettype none

module longest_dominance_chain #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic signed [COORD_BITS-1:0] point_x_i,
  input  wire logic signed [COORD_BITS-1:0] point_y_i,
  input  wire logic                         is_last_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [ldc_pkg::LenW-1:0]          chain_length_o,
  output logic                              overflow_o
);

  localparam int unsigned KEY_W    = 2 * COORD_BITS;
  localparam int unsigned LEN_W    = $clog2(MAX_POINTS + 1);
  localparam int unsigned RUN_LAST = 2 * MAX_POINTS + 2;
  localparam int unsigned CNT_W    = $clog2(RUN_LAST + 1);

  // coordinate keys: low COORD_BITS bits, sign bit flipped
  logic [COORD_BITS-1:0] x_key, y_key;
  logic [KEY_W-1:0]      new_key;

  assign x_key   = point_x_i[COORD_BITS-1:0] ^ {1'b1, {(COORD_BITS-1){1'b0}}};
  assign y_key   = point_y_i[COORD_BITS-1:0] ^ {1'b1, {(COORD_BITS-1){1'b0}}};
  assign new_key = {x_key, y_key};

  // sequencer
  ldc_pkg::state_e  state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic             dropped_q, dropped_d;
  logic             out_v_q, out_v_d;
  logic [ldc_pkg::LenW-1:0] out_len_q, out_len_d;
  logic             out_ovf_q, out_ovf_d;

  logic             in_acc, full, run_done, finish;
  ldc_pkg::row_ctrl_t row_ctrl;

  // sort row wiring
  logic [KEY_W-1:0] s_key [MAX_POINTS];
  logic [MAX_POINTS-1:0] s_v, s_ins;

  // tail row wiring: entry k feeds tail cell k
  logic [COORD_BITS-1:0] t_y [MAX_POINTS+1];
  logic [MAX_POINTS:0]   t_iv;
  logic [MAX_POINTS-1:0] t_tv, t_ext;

  assign in_stall_o = (state_q != ldc_pkg::ST_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign full       = s_v[MAX_POINTS-1];
  assign run_done   = (state_q == ldc_pkg::ST_RUN) && (cnt_q == CNT_W'(RUN_LAST));
  // result register must be free before the next result goes in
  assign finish     = run_done && (!out_v_q || !out_stall_i);

  assign row_ctrl.ins_en   = in_acc && !full;
  assign row_ctrl.drain_en = (state_q == ldc_pkg::ST_RUN);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    len_d     = len_q;
    dropped_d = dropped_q;
    out_v_d   = out_v_q && out_stall_i;
    out_len_d = out_len_q;
    out_ovf_d = out_ovf_q;
    if (|t_ext) begin
      len_d = len_q + LEN_W'(1);
    end
    unique case (state_q)
      ldc_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (full) begin
            dropped_d = 1'b1;
          end
          if (is_last_i) begin
            state_d = ldc_pkg::ST_RUN;
            cnt_d   = '0;
          end
        end
      end
      ldc_pkg::ST_RUN: begin
        if (!run_done) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
        if (finish) begin
          out_v_d   = 1'b1;
          out_len_d = (32'(len_q) > 32'(ldc_pkg::LenSat)) ?
                      ldc_pkg::LenW'(ldc_pkg::LenSat) : ldc_pkg::LenW'(len_q);
          out_ovf_d = dropped_q;
          len_d     = '0;
          dropped_d = 1'b0;
          state_d   = ldc_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = ldc_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ldc_pkg::ST_LOAD;
      cnt_q     <= '0;
      len_q     <= '0;
      dropped_q <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      len_q     <= len_d;
      dropped_q <= dropped_d;
      out_v_q   <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_len_q <= out_len_d;
    out_ovf_q <= out_ovf_d;
  end

  assign out_valid_o    = out_v_q;
  assign chain_length_o = out_len_q;
  assign overflow_o     = out_ovf_q;

  // sorting row: insert on load, drain toward cell 0 during the run
  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_sort
    logic             prev_ins, prev_v, next_v;
    logic [KEY_W-1:0] prev_key, next_key;

    if (i == 0) begin : g_first
      assign prev_ins = 1'b0;
      assign prev_key = '0;
      assign prev_v   = 1'b0;
    end else begin : g_mid
      assign prev_ins = s_ins[i-1];
      assign prev_key = s_key[i-1];
      assign prev_v   = s_v[i-1];
    end

    if (i == MAX_POINTS - 1) begin : g_last
      assign next_key = '0;
      assign next_v   = 1'b0;
    end else begin : g_inner
      assign next_key = s_key[i+1];
      assign next_v   = s_v[i+1];
    end

    ldc_sort_cell #(
      .KEY_W(KEY_W)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (row_ctrl),
      .new_key_i (new_key),
      .prev_ins_i(prev_ins),
      .prev_key_i(prev_key),
      .prev_v_i  (prev_v),
      .next_key_i(next_key),
      .next_v_i  (next_v),
      .ins_o     (s_ins[i]),
      .key_o     (s_key[i]),
      .v_o       (s_v[i])
    );
  end

  // head of the sort row feeds the tail row, y part of the key only
  assign t_y[0]  = s_key[0][COORD_BITS-1:0];
  assign t_iv[0] = row_ctrl.drain_en && s_v[0];

  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_tail
    ldc_tail_cell #(
      .Y_W(COORD_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .clear_i (finish),
      .item_v_i(t_iv[k]),
      .item_y_i(t_y[k]),
      .item_v_o(t_iv[k+1]),
      .item_y_o(t_y[k+1]),
      .tv_o    (t_tv[k]),
      .ext_o   (t_ext[k])
    );
  end

  // at most one chain gets longer per cycle, or the length counter misses one
  a_one_ext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(t_ext))
    else $error("more than one tail cell extended in a cycle");

  // filled tails and sorted points stay packed at the low end of their rows
  a_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((t_tv >> 1) & ~t_tv) == '0 && ((s_v >> 1) & ~s_v) == '0)
    else $error("row occupancy has a gap");

  // every item finds a tail within the row, none falls off its end
  a_no_spill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !t_iv[MAX_POINTS] && (t_y[MAX_POINTS] == t_y[MAX_POINTS] || 1'b1))
    else $error("item left the end of the tail row");

  // the run ends with the sort row empty and no item in flight in the tail row
  a_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_done |-> (s_v == '0) && (t_iv == '0))
    else $error("run finished with points still in flight");

  // a delivered set always holds at least one point
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> out_valid_o && (chain_length_o != '0))
    else $error("result with zero chain length");

endmodule

`default_nettype wire

// ----- sv/ldc_sort_cell.sv -----
// ldc_sort_cell: one place of the insertion sorting row
// depends on ldc_pkg (row_ctrl_t)
`default_nettype none

module ldc_sort_cell #(
  parameter int unsigned KEY_W = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ldc_pkg::row_ctrl_t ctrl_i,
  input  wire logic [KEY_W-1:0]   new_key_i,
  input  wire logic               prev_ins_i,
  input  wire logic [KEY_W-1:0]   prev_key_i,
  input  wire logic               prev_v_i,
  input  wire logic [KEY_W-1:0]   next_key_i,
  input  wire logic               next_v_i,
  output logic                    ins_o,
  output logic [KEY_W-1:0]        key_o,
  output logic                    v_o
);

  logic [KEY_W-1:0] key_q, key_d;
  logic             v_q, v_d;

  // empty places count as larger than any key
  assign ins_o = !v_q || (new_key_i < key_q);

  always_comb begin
    key_d = key_q;
    v_d   = v_q;
    if (ctrl_i.ins_en && ins_o) begin
      if (prev_ins_i) begin
        key_d = prev_key_i;
        v_d   = prev_v_i;
      end else begin
        key_d = new_key_i;
        v_d   = 1'b1;
      end
    end else if (ctrl_i.drain_en) begin
      key_d = next_key_i;
      v_d   = next_v_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;
  assign v_o   = v_q;

endmodule

`default_nettype wire

// ----- sv/ldc_tail_cell.sv -----
// ldc_tail_cell: one place of the chain-tail row; holds the smallest tail y
// of the chains of its length and passes items not below it on; no package use
`default_nettype none

module ldc_tail_cell #(
  parameter int unsigned Y_W = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           clear_i,
  input  wire logic           item_v_i,
  input  wire logic [Y_W-1:0] item_y_i,
  output logic                item_v_o,
  output logic [Y_W-1:0]      item_y_o,
  output logic                tv_o,
  output logic                ext_o
);

  logic [Y_W-1:0] tail_q, tail_d;
  logic           tv_q, tv_d;
  logic           out_v_q, out_v_d;
  logic [Y_W-1:0] out_y_q;
  logic           capture;

  // first tail strictly above y takes the item
  assign capture = item_v_i && (!tv_q || (tail_q > item_y_i));
  assign ext_o   = capture && !tv_q;

  always_comb begin
    tail_d  = tail_q;
    tv_d    = tv_q;
    out_v_d = item_v_i && !capture;
    if (capture) begin
      tail_d = item_y_i;
      tv_d   = 1'b1;
    end
    if (clear_i) begin
      tv_d    = 1'b0;
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      tv_q    <= tv_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tail_q  <= tail_d;
    out_y_q <= item_y_i;
  end

  assign item_v_o = out_v_q;
  assign item_y_o = out_y_q;
  assign tv_o     = tv_q;

endmodule

`default_nettype wire
